[sv/pftr_pkg.sv]
package pftr_pkg;

  // Default geometry
  localparam int unsigned DISPLAY_WIDTH_DEF  = 128;
  localparam int unsigned DISPLAY_HEIGHT_DEF = 64;
  localparam int unsigned GLYPH_WORDS_DEF    = 4096;

  // Field and register widths
  localparam int unsigned FW_W       = 5;
  localparam int unsigned FH_W       = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned GLYPH_BITS = 16;

  // Glyph index arithmetic: wide enough for (code - 32) * height + row and for 65536
  localparam int unsigned GIDX_W   = 17;
  // Compare width for frame byte addresses (up to 256 columns by 32 pages)
  localparam int unsigned FB_CMP_W = 14;

  localparam logic [7:0]      FIRST_CODE     = 8'd32;
  localparam logic [7:0]      LAST_CODE      = 8'd126;
  localparam logic [FW_W-1:0] FONT_WIDTH_RST  = 5'd7;
  localparam logic [FH_W-1:0] FONT_HEIGHT_RST = 6'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_FONT_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    REQ_CLEAR      = 3'd0,
    REQ_FILL       = 3'd1,
    REQ_SET_CURSOR = 3'd2,
    REQ_PIXEL      = 3'd3,
    REQ_CHAR       = 3'd4,
    REQ_LOAD       = 3'd5,
    REQ_READ       = 3'd6
  } pftr_req_e;

  typedef struct packed {
    logic capture;
    logic set_cursor;
    logic adv_cursor;
    logic glyph_we;
    logic sweep;
    logic sweep_ones;
    logic pix_we;
    logic gidx_load;
    logic gidx_sub;
    logic row_next;
    logic col_next;
    logic gly_latch;
    logic rd_latch;
    logic echo_set;
    logic out_load;
  } pftr_cmd_t;

  typedef struct packed {
    pftr_req_e req;
    logic      pix_ok;
    logic      char_ok;
    logic      draw_none;
    logic      gidx_ge;
    logic      col_last;
    logic      row_last;
    logic      sweep_last;
    logic      load_ok;
    logic      read_ok;
    logic      fill_ones;
  } pftr_stat_t;

endpackage

[sv/pftr_ram.sv]
module pftr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pftr_ctrl.sv]
module pftr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  pftr_pkg::pftr_stat_t stat_i,
  output pftr_pkg::pftr_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISPATCH,
    S_SWEEP,
    S_PIX_WR,
    S_RD_WAIT,
    S_CH_MOD,
    S_CH_ROW,
    S_CH_GLY,
    S_CH_PRD,
    S_CH_PWR,
    S_CH_END,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.req)
          pftr_pkg::REQ_CLEAR, pftr_pkg::REQ_FILL: state_d = S_SWEEP;
          pftr_pkg::REQ_SET_CURSOR: begin
            cmd_o.set_cursor = 1'b1;
            state_d          = S_DONE;
          end
          pftr_pkg::REQ_PIXEL: state_d = stat_i.pix_ok ? S_PIX_WR : S_DONE;
          pftr_pkg::REQ_CHAR: begin
            if (stat_i.char_ok) begin
              cmd_o.gidx_load = 1'b1;
              state_d         = S_CH_MOD;
            end else begin
              state_d = S_DONE;
            end
          end
          pftr_pkg::REQ_LOAD: begin
            cmd_o.glyph_we = stat_i.load_ok;
            state_d        = S_DONE;
          end
          pftr_pkg::REQ_READ: state_d = S_RD_WAIT;
          default: state_d = S_DONE;
        endcase
      end
      S_SWEEP: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_ones = stat_i.fill_ones;
        if (stat_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_PIX_WR: begin
        cmd_o.pix_we = 1'b1;
        state_d      = S_DONE;
      end
      S_RD_WAIT: begin
        cmd_o.rd_latch = stat_i.read_ok;
        state_d        = S_DONE;
      end
      S_CH_MOD: begin
        priority if (stat_i.gidx_ge) begin
          cmd_o.gidx_sub = 1'b1;
        end else if (stat_i.draw_none) begin
          state_d = S_CH_END;
        end else begin
          state_d = S_CH_ROW;
        end
      end
      S_CH_ROW: state_d = S_CH_GLY;
      S_CH_GLY: begin
        cmd_o.gly_latch = 1'b1;
        state_d         = S_CH_PWR;
      end
      S_CH_PRD: state_d = S_CH_PWR;
      S_CH_PWR: begin
        cmd_o.pix_we = 1'b1;
        priority if (!stat_i.col_last) begin
          cmd_o.col_next = 1'b1;
          state_d        = S_CH_PRD;
        end else if (!stat_i.row_last) begin
          cmd_o.row_next = 1'b1;
          state_d        = S_CH_ROW;
        end else begin
          state_d = S_CH_END;
        end
      end
      S_CH_END: begin
        cmd_o.adv_cursor = 1'b1;
        cmd_o.echo_set   = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_dispatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DISPATCH))
    else $error("accepted word not dispatched");

  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i)) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not loaded into output register");

  a_pwr_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CH_PWR) |-> ($past(state_q) == S_CH_GLY || $past(state_q) == S_CH_PRD))
    else $error("glyph pixel written without a preceding frame read");

endmodule

[sv/pftr_dp.sv]
module pftr_dp #(
  parameter int unsigned DISPLAY_WIDTH  = pftr_pkg::DISPLAY_WIDTH_DEF,
  parameter int unsigned DISPLAY_HEIGHT = pftr_pkg::DISPLAY_HEIGHT_DEF,
  parameter int unsigned GLYPH_WORDS    = pftr_pkg::GLYPH_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pftr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pftr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [2:0]                      req_type_i,
  input  logic [7:0]                      pos_x_i,
  input  logic [7:0]                      pos_y_i,
  input  logic                            color_i,
  input  logic [7:0]                      char_code_i,
  input  logic [11:0]                     glyph_addr_i,
  input  logic [15:0]                     glyph_word_i,
  input  logic [9:0]                      buffer_addr_i,
  output logic [7:0]                      char_echo_o,
  output logic [7:0]                      read_data_o,
  input  pftr_pkg::pftr_cmd_t             cmd_i,
  output pftr_pkg::pftr_stat_t            stat_o
);

  localparam int unsigned FRAME_PAGES = (DISPLAY_HEIGHT + 7) / 8;
  localparam int unsigned FRAME_BYTES = DISPLAY_WIDTH * FRAME_PAGES;
  localparam int unsigned FA_W        = $clog2(FRAME_BYTES);
  localparam int unsigned GA_W        = $clog2(GLYPH_WORDS);
  localparam int unsigned GIDX_W      = pftr_pkg::GIDX_W;
  localparam int unsigned CMP_W       = pftr_pkg::FB_CMP_W;

  // Captured request
  pftr_pkg::pftr_req_e req_q;
  logic [7:0]          px_q, py_q, code_q;
  logic                lit_q;
  logic [11:0]         gaddr_q;
  logic [15:0]         gword_q;
  logic [9:0]          baddr_q;

  // Configuration and cursor
  logic [pftr_pkg::FW_W-1:0] fw_q;
  logic [pftr_pkg::FH_W-1:0] fh_q;
  logic [7:0]                cur_col_q, cur_row_q;

  // Draw and sweep counters
  logic [FA_W-1:0]           sw_q;
  logic [pftr_pkg::FW_W-1:0] c_q;
  logic [pftr_pkg::FH_W-1:0] r_q;
  logic [GIDX_W-1:0]         gidx_q, gidx_d, gidx_inc;
  logic [pftr_pkg::GLYPH_BITS-1:0] gw_q;

  // Result staging and output register
  logic [7:0] res_echo_q, res_rd_q;
  logic [7:0] out_echo_q, out_rd_q;

  logic [7:0]      pix_col, pix_row, pix_mask, pix_byte, fr_rdata, sweep_byte;
  logic [FA_W-1:0] pix_addr, fr_raddr, fr_waddr;
  logic [7:0]      fr_wdata;
  logic            is_char, gbit, pix_on;
  logic [6:0]      code_off;
  logic [12:0]     base_idx;
  logic [pftr_pkg::GLYPH_BITS-1:0] gl_rdata;

  assign is_char  = (req_q == pftr_pkg::REQ_CHAR);
  assign pix_col  = is_char ? 8'(cur_col_q + 8'(c_q)) : px_q;
  assign pix_row  = is_char ? 8'(cur_row_q + 8'(r_q)) : py_q;
  assign pix_addr = FA_W'(pix_col) + FA_W'(pix_row[7:3]) * FA_W'(DISPLAY_WIDTH);
  assign pix_mask = 8'd1 << pix_row[2:0];

  // Columns beyond the 16 bits of the glyph word count as clear
  assign gbit   = !c_q[4] && gw_q[4'd15 - c_q[3:0]];
  assign pix_on = is_char ? (gbit ? lit_q : !lit_q) : lit_q;
  assign pix_byte = pix_on ? (fr_rdata | pix_mask) : (fr_rdata & ~pix_mask);

  assign sweep_byte = cmd_i.sweep_ones ? 8'hFF : 8'h00;
  assign fr_waddr   = cmd_i.sweep ? sw_q : pix_addr;
  assign fr_wdata   = cmd_i.sweep ? sweep_byte : pix_byte;
  assign fr_raddr   = (req_q == pftr_pkg::REQ_READ) ? FA_W'(baddr_q) : pix_addr;

  assign code_off = 7'(code_q - pftr_pkg::FIRST_CODE);
  assign base_idx = 13'(code_off) * 13'(fh_q);
  assign gidx_inc = gidx_q + GIDX_W'(1);

  always_comb begin
    gidx_d = gidx_q;
    priority if (cmd_i.gidx_load) begin
      gidx_d = GIDX_W'(base_idx);
    end else if (cmd_i.gidx_sub) begin
      gidx_d = gidx_q - GIDX_W'(GLYPH_WORDS);
    end else if (cmd_i.row_next) begin
      gidx_d = (gidx_inc == GIDX_W'(GLYPH_WORDS)) ? '0 : gidx_inc;
    end else begin
      gidx_d = gidx_q;
    end
  end

  pftr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sweep || cmd_i.pix_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  pftr_ram #(
    .WIDTH (pftr_pkg::GLYPH_BITS),
    .DEPTH (GLYPH_WORDS)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.glyph_we),
    .waddr_i (GA_W'(gaddr_q)),
    .wdata_i (gword_q),
    .raddr_i (gidx_q[GA_W-1:0]),
    .rdata_o (gl_rdata)
  );

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= pftr_pkg::pftr_req_e'(req_type_i);
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      lit_q   <= color_i;
      code_q  <= char_code_i;
      gaddr_q <= glyph_addr_i;
      gword_q <= glyph_word_i;
      baddr_q <= buffer_addr_i;
    end
    gidx_q <= gidx_d;
    if (cmd_i.gly_latch) begin
      gw_q <= gl_rdata;
    end
    if (cmd_i.capture) begin
      res_echo_q <= '0;
      res_rd_q   <= '0;
    end else begin
      if (cmd_i.echo_set) begin
        res_echo_q <= code_q;
      end
      if (cmd_i.rd_latch) begin
        res_rd_q <= fr_rdata;
      end
    end
    if (cmd_i.out_load) begin
      out_echo_q <= res_echo_q;
      out_rd_q   <= res_rd_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= pftr_pkg::FONT_WIDTH_RST;
      fh_q      <= pftr_pkg::FONT_HEIGHT_RST;
      cur_col_q <= '0;
      cur_row_q <= '0;
      sw_q      <= '0;
      c_q       <= '0;
      r_q       <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == pftr_pkg::CFG_FONT_WIDTH) begin
        fw_q <= cfg_data_i[pftr_pkg::FW_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == pftr_pkg::CFG_FONT_HEIGHT) begin
        fh_q <= cfg_data_i[pftr_pkg::FH_W-1:0];
      end
      if (cmd_i.set_cursor) begin
        cur_col_q <= px_q;
        cur_row_q <= py_q;
      end else if (cmd_i.adv_cursor) begin
        cur_col_q <= 8'(cur_col_q + 8'(fw_q));
      end
      if (cmd_i.sweep) begin
        sw_q <= stat_o.sweep_last ? '0 : FA_W'(sw_q + FA_W'(1));
      end
      if (cmd_i.gidx_load || cmd_i.row_next) begin
        c_q <= '0;
      end else if (cmd_i.col_next) begin
        c_q <= c_q + 1'b1;
      end
      if (cmd_i.gidx_load) begin
        r_q <= '0;
      end else if (cmd_i.row_next) begin
        r_q <= r_q + 1'b1;
      end
    end
  end

  assign stat_o.req        = req_q;
  assign stat_o.pix_ok     = (9'(px_q) < 9'(DISPLAY_WIDTH)) && (9'(py_q) < 9'(DISPLAY_HEIGHT));
  assign stat_o.char_ok    = (code_q >= pftr_pkg::FIRST_CODE) && (code_q <= pftr_pkg::LAST_CODE)
                          && ((9'(cur_col_q) + 9'(fw_q)) < 9'(DISPLAY_WIDTH))
                          && ((9'(cur_row_q) + 9'(fh_q)) < 9'(DISPLAY_HEIGHT));
  assign stat_o.draw_none  = (fw_q == '0) || (fh_q == '0);
  assign stat_o.gidx_ge    = (gidx_q >= GIDX_W'(GLYPH_WORDS));
  assign stat_o.col_last   = (c_q == pftr_pkg::FW_W'(fw_q - 1'b1));
  assign stat_o.row_last   = (r_q == pftr_pkg::FH_W'(fh_q - 1'b1));
  assign stat_o.sweep_last = (sw_q == FA_W'(FRAME_BYTES - 1));
  assign stat_o.load_ok    = (GIDX_W'(gaddr_q) < GIDX_W'(GLYPH_WORDS));
  assign stat_o.read_ok    = (CMP_W'(baddr_q) < CMP_W'(FRAME_BYTES));
  assign stat_o.fill_ones  = (req_q == pftr_pkg::REQ_FILL) && lit_q;

  assign char_echo_o = out_echo_q;
  assign read_data_o = out_rd_q;

  a_one_writer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.sweep && cmd_i.pix_we))
    else $error("sweep and pixel write collide on the frame store");

  a_glyph_idx_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gly_latch |-> (gidx_q < GIDX_W'(GLYPH_WORDS)))
    else $error("glyph row index not reduced below store depth");

  a_pix_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pix_we |-> (CMP_W'(pix_addr) < CMP_W'(FRAME_BYTES)))
    else $error("pixel write outside the frame store");

endmodule

[sv/page_framebuffer_text_renderer.sv]
// Monochrome page framebuffer with an opaque glyph blitter. The frame store
// holds DISPLAY_WIDTH columns by DISPLAY_HEIGHT rows in 8-row pages: byte
// (page * DISPLAY_WIDTH + column), bit n is row page * 8 + n. Each accepted
// word yields exactly one result word (char_echo, read_data), both zero unless
// the request is put char or read byte. Request code seven returns a zero
// result and does nothing else. Clear and fill write one frame byte per
// cycle from the sweep counter. A put char that is drawn first subtracts
// GLYPH_WORDS from the first glyph row index until it lies in the store
// (not needed at the default sizes), then walks the glyph: every pixel is a
// read-modify-write of the frame store, plus one glyph store read per row.
// A zero font_width or font_height skips the walk. After reset the block
// runs a clearing pass that zeroes all FRAME_BYTES bytes (1024 by default)
// of the frame store; stall stays high until it ends, though configuration
// writes are taken. The glyph store is not cleared and must be loaded before
// use. Write font_width and font_height only while the block is idle.
module page_framebuffer_text_renderer #(
  parameter int unsigned DISPLAY_WIDTH  = pftr_pkg::DISPLAY_WIDTH_DEF,
  parameter int unsigned DISPLAY_HEIGHT = pftr_pkg::DISPLAY_HEIGHT_DEF,
  parameter int unsigned GLYPH_WORDS    = pftr_pkg::GLYPH_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [pftr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pftr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request word
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      req_type_i,
  input  logic [7:0]                      pos_x_i,
  input  logic [7:0]                      pos_y_i,
  input  logic                            color_i,
  input  logic [7:0]                      char_code_i,
  input  logic [11:0]                     glyph_addr_i,
  input  logic [15:0]                     glyph_word_i,
  input  logic [9:0]                      buffer_addr_i,
  // result word
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      char_echo_o,
  output logic [7:0]                      read_data_o
);

  pftr_pkg::pftr_cmd_t  cmd;
  pftr_pkg::pftr_stat_t stat;

  // Sequencer: accepts a word, walks the request through the datapath and
  // hands the result to the output register, which holds it while stalled.
  pftr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: request capture, cursor, font registers, frame and glyph
  // stores, pixel read-modify-write and the output register.
  pftr_dp #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .GLYPH_WORDS    (GLYPH_WORDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .color_i       (color_i),
    .char_code_i   (char_code_i),
    .glyph_addr_i  (glyph_addr_i),
    .glyph_word_i  (glyph_word_i),
    .buffer_addr_i (buffer_addr_i),
    .char_echo_o   (char_echo_o),
    .read_data_o   (read_data_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule
